// ===== rtl/kws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kws_pkg;
   localparam int THR_BITS = 16;
   localparam int INDEX_BITS = 6;

   typedef struct packed {
      logic busy;
      logic done;
   } kws_div_stat_type;
endpackage
`default_nettype wire

// ===== rtl/kws_sample_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kws_sample_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6,
   parameter int WB = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [WB-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [WB-1:0] rd_data
);
   logic [WB-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/kws_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kws_div #(
   parameter int WB = 16,
   parameter int AW = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [WB-1:0]           dividend,
   input  wire logic [AW-1:0]           divisor,
   output kws_pkg::kws_div_stat_type    stat,
   output logic      [WB-1:0]           quotient,
   output logic      [AW-1:0]           remainder
);
   import kws_pkg::*;

   localparam int CB = $clog2(WB + 1);

   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [WB-1:0] quo_ff, quo_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] div_ff, div_in;
   logic [AW:0]   trial;
   logic [AW:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[WB-1]};
      diff = trial - {1'b0, div_ff};
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = CB'(WB);
         busy_in = 1'b1;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[AW-1:0];
            quo_in = {quo_ff[WB-2:0], 1'b1};
         end else begin
            rem_in = trial[AW-1:0];
            quo_in = {quo_ff[WB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
endmodule
`default_nettype wire

// ===== rtl/keyframe_weight_simplifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  ports
// req       in         req_valid, req_stall, req_sample_weight, req_is_last
// rsp       out        rsp_valid, rsp_stall, rsp_kept_index, rsp_kept_weight,
//                      rsp_last_kept, rsp_overflow
// csr       in         csr_valid, csr_ready, csr_error_threshold
//
// loading takes one request per cycle into the sample memory
// after the final request the run is simplified: each segment passes through
// stack pop, endpoint reads, the shared divider, a scan of its interior
// samples and the decision, with a second stack push when it splits
// each kept sample then leaves through a memory read and the output register,
// where it holds while rsp_stall is high; each dropped one is only skipped
// reset clears control state; sample memory holds no reset value
// req_stall is high for the whole simplify and emit phase; rsp_stall holds
// the output register
module keyframe_weight_simplifier #(
   parameter int MAX_SAMPLES = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [WEIGHT_BITS-1:0]     req_sample_weight,
   input  wire logic                              req_is_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic        [kws_pkg::INDEX_BITS-1:0]  rsp_kept_index,
   output logic signed [WEIGHT_BITS-1:0]          rsp_kept_weight,
   output logic                                   rsp_last_kept,
   output logic                                   rsp_overflow,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic signed [kws_pkg::THR_BITS-1:0] csr_error_threshold
);
   import kws_pkg::*;

   localparam int WB = WEIGHT_BITS;
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NB = $clog2(MAX_SAMPLES + 1);
   localparam int CW = (WB + 1 > THR_BITS) ? WB + 1 : THR_BITS;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_SEG   = 4'd3;
   localparam logic [3:0] S_RDH   = 4'd4;
   localparam logic [3:0] S_RDT   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_DEC   = 4'd8;
   localparam logic [3:0] S_PUSH2 = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;
   localparam logic [3:0] S_EMLD  = 4'd11;
   localparam logic [3:0] S_HOLD  = 4'd12;

   logic [3:0]             state_ff, state_in;
   logic [NB-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic signed [THR_BITS-1:0] thr_ff, thr_in;
   logic [MAX_SAMPLES-1:0] keep_ff, keep_in;
   logic [NB-1:0]          sp_ff, sp_in;
   logic [AW-1:0]          h_ff, h_in, t_ff, t_in;
   logic [WB-1:0]          wh_ff, wh_in;
   logic                   neg_ff, neg_in;
   logic [AW-1:0]          tot_ff, tot_in;
   logic [WB-1:0]          dq_ff, dq_in, q_ff, q_in;
   logic [AW-1:0]          dr_ff, dr_in, r_ff, r_in;
   logic [AW-1:0]          i_ff, i_in;
   logic [WB:0]            maxerr_ff, maxerr_in;
   logic [AW-1:0]          best_ff, best_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [WB-1:0]          rsp_weight_ff, rsp_weight_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [2*AW-1:0]        stack_mem [MAX_SAMPLES];
   logic [2*AW-1:0]        stack_rd_ff;
   logic                   st_we;
   logic [AW-1:0]          st_waddr, st_raddr;
   logic [2*AW-1:0]        st_wdata;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   logic [WB-1:0]          mem_rdata;

   logic                   div_start;
   logic [WB-1:0]          div_dividend;
   kws_div_stat_type       div_stat;
   logic [WB-1:0]          div_quo;
   logic [AW-1:0]          div_rem;

   logic                   req_accept;
   logic [AW-1:0]          last_idx;
   logic [AW-1:0]          seg_h, seg_t;
   logic signed [WB:0]     d_full;
   logic [WB:0]            q_ext, line_off;
   logic signed [WB:0]     line_val;
   logic signed [WB+1:0]   diff;
   logic [WB+1:0]          abs_diff;
   logic [WB:0]            err;
   logic [AW:0]            r_sum;
   logic [CW-1:0]          err_cmp, thr_cmp;

   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[st_waddr] <= st_wdata;
      end
      stack_rd_ff <= stack_mem[st_raddr];
   end

   kws_sample_mem #(.DEPTH(MAX_SAMPLES), .AW(AW), .WB(WB)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_sample_weight),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   kws_div #(.WB(WB), .AW(AW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (tot_in),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign last_idx = AW'(count_ff - 1'b1);
   assign seg_h = stack_rd_ff[2*AW-1:AW];
   assign seg_t = stack_rd_ff[AW-1:0];
   assign mem_we = req_accept && (count_ff < NB'(MAX_SAMPLES));
   assign mem_waddr = count_ff[AW-1:0];

   always_comb begin
      d_full = $signed({mem_rdata[WB-1], mem_rdata}) - $signed({wh_ff[WB-1], wh_ff});
      div_dividend = d_full[WB] ? WB'(-d_full) : d_full[WB-1:0];
      q_ext = {1'b0, q_ff};
      line_off = neg_ff ? -q_ext : q_ext;
      line_val = $signed({wh_ff[WB-1], wh_ff}) + $signed(line_off);
      diff = $signed({line_val[WB], line_val}) - $signed({{2{mem_rdata[WB-1]}}, mem_rdata});
      abs_diff = diff[WB+1] ? -diff : diff;
      err = abs_diff[WB:0];
      r_sum = {1'b0, r_ff} + {1'b0, dr_ff};
      err_cmp = CW'(maxerr_ff);
      thr_cmp = CW'(thr_ff[THR_BITS-2:0]);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      thr_in = csr_valid ? csr_error_threshold : thr_ff;
      keep_in = keep_ff;
      sp_in = sp_ff;
      h_in = h_ff;
      t_in = t_ff;
      wh_in = wh_ff;
      neg_in = neg_ff;
      tot_in = tot_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      q_in = q_ff;
      r_in = r_ff;
      i_in = i_ff;
      maxerr_in = maxerr_ff;
      best_in = best_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in = rsp_ovf_ff;
      st_we = 1'b0;
      st_waddr = sp_ff[AW-1:0];
      st_wdata = '0;
      st_raddr = '0;
      mem_raddr = '0;
      div_start = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (count_ff < NB'(MAX_SAMPLES)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            idx_in = '0;
            if (thr_ff[THR_BITS-1]) begin
               for (int k = 0; k < MAX_SAMPLES; k++) begin
                  if (NB'(k) < count_ff) begin
                     keep_in[k] = 1'b1;
                  end
               end
               state_in = S_EMIT;
            end else begin
               keep_in[0] = 1'b1;
               keep_in[last_idx] = 1'b1;
               if (count_ff < NB'(3)) begin
                  state_in = S_EMIT;
               end else begin
                  st_we = 1'b1;
                  st_waddr = '0;
                  st_wdata = {AW'(0), last_idx};
                  sp_in = NB'(1);
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               idx_in = '0;
               state_in = S_EMIT;
            end else begin
               sp_in = sp_ff - 1'b1;
               st_raddr = sp_in[AW-1:0];
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            h_in = seg_h;
            t_in = seg_t;
            mem_raddr = seg_h;
            if ({1'b0, seg_t} >= count_ff || seg_h >= seg_t
                  || (seg_t - seg_h) < AW'(2)) begin
               state_in = S_POP;
            end else begin
               state_in = S_RDH;
            end
         end
         S_RDH: begin
            wh_in = mem_rdata;
            mem_raddr = t_ff;
            state_in = S_RDT;
         end
         S_RDT: begin
            neg_in = d_full[WB];
            tot_in = t_ff - h_ff;
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               dq_in = div_quo;
               dr_in = div_rem;
               q_in = div_quo;
               r_in = div_rem;
               i_in = h_ff + 1'b1;
               mem_raddr = i_in;
               maxerr_in = '0;
               best_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (err > maxerr_ff) begin
               maxerr_in = err;
               best_in = i_ff;
            end
            if (r_sum >= {1'b0, tot_ff}) begin
               r_in = AW'(r_sum - {1'b0, tot_ff});
               q_in = q_ff + dq_ff + 1'b1;
            end else begin
               r_in = r_sum[AW-1:0];
               q_in = q_ff + dq_ff;
            end
            i_in = i_ff + 1'b1;
            mem_raddr = i_in;
            if (i_ff == t_ff - 1'b1) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (err_cmp > thr_cmp) begin
               keep_in[best_ff] = 1'b1;
               if (sp_ff < NB'(MAX_SAMPLES)) begin
                  st_we = 1'b1;
                  st_wdata = {best_ff, t_ff};
                  sp_in = sp_ff + 1'b1;
               end
               state_in = S_PUSH2;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH2: begin
            if (sp_ff < NB'(MAX_SAMPLES)) begin
               st_we = 1'b1;
               st_wdata = {h_ff, best_ff};
               sp_in = sp_ff + 1'b1;
            end
            state_in = S_POP;
         end
         S_EMIT: begin
            mem_raddr = idx_ff;
            if (keep_ff[idx_ff]) begin
               state_in = S_EMLD;
            end else if (idx_ff == last_idx) begin
               keep_in = '0;
               count_in = '0;
               ovf_in = 1'b0;
               sp_in = '0;
               state_in = S_LOAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EMLD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = INDEX_BITS'(idx_ff);
            rsp_weight_in = mem_rdata;
            rsp_last_in = (idx_ff == last_idx);
            rsp_ovf_in = ovf_ff;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  keep_in = '0;
                  count_in = '0;
                  ovf_in = 1'b0;
                  sp_in = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         thr_ff <= '0;
         keep_ff <= '0;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         thr_ff <= thr_in;
         keep_ff <= keep_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff <= h_in;
      t_ff <= t_in;
      wh_ff <= wh_in;
      neg_ff <= neg_in;
      tot_ff <= tot_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      q_ff <= q_in;
      r_ff <= r_in;
      i_ff <= i_in;
      maxerr_ff <= maxerr_in;
      best_ff <= best_in;
      idx_ff <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kept_index = rsp_index_ff;
   assign rsp_kept_weight = rsp_weight_ff;
   assign rsp_last_kept = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= NB'(MAX_SAMPLES)) else $error("segment stack overrun");
   a_scan_inside: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (i_ff > h_ff && i_ff < t_ff))
      else $error("scan index outside segment");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV) else $error("divider result unexpected");
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_kept) |=> (count_ff == '0 && keep_ff == '0))
      else $error("run state not cleared");
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during emit");
endmodule
`default_nettype wire
